// ----- hdl/tldpg_pkg.sv -----
// ----------------------------------------------------------------------------
// tldpg_pkg
// Shared widths, register indexes and types for the trigger locked double
// pulse generator.
// ----------------------------------------------------------------------------
package tldpg_pkg;

	localparam int COUNT_WIDTH = 24;
	localparam int CFG_WIDTH   = 24;
	localparam int IDX_WIDTH   = 3;
	localparam int HALF_WIDTH  = COUNT_WIDTH - 1;
	// window sums are formed wide enough never to wrap
	localparam int SUM_WIDTH   = ((COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH) + 2;

	localparam logic [63:0] CNT_MOD = (64'd1 << COUNT_WIDTH) - 64'd1;
	localparam logic [COUNT_WIDTH-1:0] CNT_LAST = COUNT_WIDTH'(CNT_MOD - 64'd1);
	localparam logic [COUNT_WIDTH-1:0] PERIOD_RESET = COUNT_WIDTH'(64'd49800 % CNT_MOD);

	localparam logic [IDX_WIDTH-1:0] REG_OFFSET_A   = 3'd0;
	localparam logic [IDX_WIDTH-1:0] REG_DURATION_A = 3'd1;
	localparam logic [IDX_WIDTH-1:0] REG_INVERT_A   = 3'd2;
	localparam logic [IDX_WIDTH-1:0] REG_OFFSET_B   = 3'd3;
	localparam logic [IDX_WIDTH-1:0] REG_DURATION_B = 3'd4;
	localparam logic [IDX_WIDTH-1:0] REG_INVERT_B   = 3'd5;

	localparam logic [CFG_WIDTH-1:0] OFFSET_A_RESET   = 24'd9000;
	localparam logic [CFG_WIDTH-1:0] DURATION_A_RESET = 24'd6000;
	localparam logic [CFG_WIDTH-1:0] OFFSET_B_RESET   = 24'd0;
	localparam logic [CFG_WIDTH-1:0] DURATION_B_RESET = 24'd6000;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] offset;
		logic [CFG_WIDTH-1:0] duration;
		logic                 invert;
	} chan_cfg_t;

endpackage

// ----- hdl/tldpg_window.sv -----
// ----------------------------------------------------------------------------
// tldpg_window
// Pulse window test for one channel: the main window after the trigger and
// the same window shifted by half the measured period, then inversion.
// ----------------------------------------------------------------------------
module tldpg_window import tldpg_pkg::*; (
	input  logic [COUNT_WIDTH-1:0] t,
	input  logic [HALF_WIDTH-1:0]  half,
	input  chan_cfg_t              cfg,
	output logic                   level
);

	logic [SUM_WIDTH-1:0] t_w;
	logic [SUM_WIDTH-1:0] open_w;
	logic [SUM_WIDTH-1:0] close_w;
	logic [SUM_WIDTH-1:0] open2_w;
	logic [SUM_WIDTH-1:0] close2_w;
	logic                 active;

	always_comb begin
		t_w      = SUM_WIDTH'(t);
		open_w   = SUM_WIDTH'(cfg.offset);
		close_w  = open_w + SUM_WIDTH'(cfg.duration);
		open2_w  = open_w + SUM_WIDTH'(half);
		close2_w = close_w + SUM_WIDTH'(half);
		active   = ((t_w > open_w) && (t_w < close_w)) ||
			((t_w > open2_w) && (t_w < close2_w));
		level    = active ^ cfg.invert;
	end

endmodule

// ----- hdl/trigger_locked_double_pulse_generator.sv -----
// Pipeline: an accepted input beat is held in the first stage register, then in the result
// register; out_stall holds the result register and, while that is full, stalls the input.
// Throughput: one input beat per cycle while in_stall is low; the tick counter and period latch
// update at each accepted beat, window compares sit between the two registers.
// Reset: asynchronous, active low; count clears to zero, measured period
// loads 49800 and the channel registers take their default values.
// ----------------------------------------------------------------------------
// trigger_locked_double_pulse_generator
// Counts ticks since the last trigger, latches the period on each trigger and
// drives two inverted-or-not pulse channels at twice the trigger rate.
// ----------------------------------------------------------------------------
module trigger_locked_double_pulse_generator import tldpg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 trigger_edge,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 level_a,
	output logic                 level_b,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [IDX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0] cfg_data
);

	chan_cfg_t cfg_a_q;
	chan_cfg_t cfg_b_q;

	logic [COUNT_WIDTH-1:0] elapsed_q;
	logic [COUNT_WIDTH-1:0] period_q;
	logic [COUNT_WIDTH-1:0] t_now;
	logic [COUNT_WIDTH-1:0] period_now;

	logic                   s1_valid_q;
	logic [COUNT_WIDTH-1:0] t_s1;
	logic [HALF_WIDTH-1:0]  half_s1;

	logic out_free;
	logic in_accept;
	logic lvl_a;
	logic lvl_b;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_a_q.offset   <= OFFSET_A_RESET;
			cfg_a_q.duration <= DURATION_A_RESET;
			cfg_a_q.invert   <= 1'b1;
			cfg_b_q.offset   <= OFFSET_B_RESET;
			cfg_b_q.duration <= DURATION_B_RESET;
			cfg_b_q.invert   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OFFSET_A:   cfg_a_q.offset   <= cfg_data;
				REG_DURATION_A: cfg_a_q.duration <= cfg_data;
				REG_INVERT_A:   cfg_a_q.invert   <= cfg_data[0];
				REG_OFFSET_B:   cfg_b_q.offset   <= cfg_data;
				REG_DURATION_B: cfg_b_q.duration <= cfg_data;
				REG_INVERT_B:   cfg_b_q.invert   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pipeline control: the output register frees when empty or taken
	assign out_free  = !out_valid || !out_stall;
	assign in_stall  = s1_valid_q && !out_free;
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		t_now      = trigger_edge ? '0 : elapsed_q;
		period_now = trigger_edge ? elapsed_q : period_q;
	end

	// tick counter and period latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			period_q  <= PERIOD_RESET;
		end else if (in_accept) begin
			period_q  <= period_now;
			// count wraps one short of all ones
			elapsed_q <= (t_now == CNT_LAST) ? '0 : t_now + COUNT_WIDTH'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (out_free) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			t_s1    <= t_now;
			half_s1 <= period_now[COUNT_WIDTH-1:1];
		end
	end

	tldpg_window u_win_a (
		.t     (t_s1),
		.half  (half_s1),
		.cfg   (cfg_a_q),
		.level (lvl_a)
	);

	tldpg_window u_win_b (
		.t     (t_s1),
		.half  (half_s1),
		.cfg   (cfg_b_q),
		.level (lvl_b)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_valid_q) begin
			level_a <= lvl_a;
			level_b <= lvl_b;
		end
	end

	a_count_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		elapsed_q != '1)
		else $error("tick count reached the wrap value");

	a_trigger_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && trigger_edge) |=> (elapsed_q == COUNT_WIDTH'(1)))
		else $error("count did not restart after trigger beat");

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> !in_stall)
		else $error("input stalled with empty first stage");

	a_result_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(s1_valid_q))
		else $error("result beat without a first stage item");

endmodule
